// ===== hdl/pds_pkg.sv =====
// Package for the PLL divider search core: beat types, status codes and search limits.
// Depends on nothing; every other file in hdl imports it.

package pds_pkg;

	localparam int MAX_OUT_SHIFT = 5;
	localparam int MAX_MULT      = 128;
	localparam int MAX_IN_DIV    = 8;

	localparam int OSC_W   = 26;
	localparam int TGT_W   = 32;
	localparam int RANGE_W = 3;
	localparam int SHIFT_W = 3;
	localparam int MULT_W  = 7;
	localparam int DIV_W   = 3;

	localparam logic [OSC_W-1:0] OSC_RESET_HZ = OSC_W'(8000000);
	localparam logic [OSC_W-1:0] RC_HZ        = OSC_W'(8000000);
	localparam logic [OSC_W-1:0] RANGE1_LIM   = OSC_W'(10000000);
	localparam logic [OSC_W-1:0] RANGE2_LIM   = OSC_W'(16000000);
	localparam logic [OSC_W-1:0] RANGE3_LIM   = OSC_W'(26000000);
	localparam logic [OSC_W-1:0] RANGE4_LIM   = OSC_W'(42000000);
	localparam logic [OSC_W-1:0] RANGE5_LIM   = OSC_W'(64000000);

	typedef enum logic [1:0] {
		STATUS_FOUND       = 2'd0,
		STATUS_TOO_FAST    = 2'd1,
		STATUS_NO_SOLUTION = 2'd2
	} status_t;

	typedef struct packed {
		logic [TGT_W-1:0] target_hz;
		logic             use_internal_rc;
	} in_beat_t;

	typedef struct packed {
		status_t            status;
		logic [RANGE_W-1:0] input_range_code;
		logic [SHIFT_W-1:0] output_shift;
		logic [MULT_W-1:0]  mult_code;
		logic [DIV_W-1:0]   in_div_code;
	} out_beat_t;

endpackage

// ===== hdl/pll_divider_search_core.sv =====
// Top level of the PLL divider search core: range selection, quotient precompute and search.
// Depends on pds_pkg for beat types, status codes and search limits.

// An accepted beat keeps the core busy until its result is loaded into the output register.
// The PLL input frequency is first divided by each input divider 1..8 in a shared
// one-bit-per-cycle divider. Then one quotient-times-multiplier unit tests one candidate
// per cycle, output shift outermost and input divider innermost, over at most 5 x 128 x 8
// candidates; then the pipeline drains and the result is loaded. The search stops at the
// first match. A beat on an oscillator at 64 MHz or above, without the internal RC, is
// answered as too fast with no search. A finished result sits in an output register, so the
// next beat can be taken while it waits; a previous result still stalled there holds the
// core in its last step until it is taken.
module pll_divider_search_core
	import pds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [OSC_W-1:0] cfg_write_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_beat_t         in_beat,
	output logic             out_valid,
	input  logic             out_stall,
	output out_beat_t        out_beat
);

	localparam int BIT_W  = $clog2(OSC_W);
	localparam int PROD_W = OSC_W + MULT_W + 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [OSC_W-1:0]   osc_q;
	logic [OSC_W-1:0]   src_q;
	logic [TGT_W-1:0]   target_q;
	logic [RANGE_W-1:0] range_q;
	out_beat_t          res_q;
	out_beat_t          out_q;
	logic               out_valid_q;

	logic [DIV_W-1:0]   dsel_q;
	logic [BIT_W-1:0]   bit_q;
	logic [DIV_W-1:0]   rem_q;
	logic [OSC_W-1:0]   quot_q;
	logic [OSC_W-1:0]   quot_mem_q [MAX_IN_DIV];

	logic               issue_q;
	logic [SHIFT_W-1:0] shift_q;
	logic [MULT_W-1:0]  mult_q;
	logic [DIV_W-1:0]   div_q;

	logic               valid_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic [SHIFT_W-1:0] shift_s1;
	logic [MULT_W-1:0]  mult_s1;
	logic [DIV_W-1:0]   div_s1;

	logic               accept;
	logic               load_out;
	logic [RANGE_W-1:0] osc_range;
	logic [DIV_W:0]     divisor;
	logic [DIV_W:0]     trial;
	logic               qbit;
	logic [DIV_W-1:0]   rem_next;
	logic [MULT_W:0]    mult_val;
	logic               match;
	logic               last_cand;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign load_out  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

	always_comb begin
		if (osc_q < RANGE1_LIM) begin
			osc_range = RANGE_W'(1);
		end else if (osc_q < RANGE2_LIM) begin
			osc_range = RANGE_W'(2);
		end else if (osc_q < RANGE3_LIM) begin
			osc_range = RANGE_W'(3);
		end else if (osc_q < RANGE4_LIM) begin
			osc_range = RANGE_W'(4);
		end else if (osc_q < RANGE5_LIM) begin
			osc_range = RANGE_W'(5);
		end else begin
			osc_range = '0;
		end
	end

	// One restoring step of the shared divider: remainder stays below the divisor.
	always_comb begin
		divisor = {1'b0, dsel_q} + (DIV_W+1)'(1);
		trial   = {rem_q, src_q[bit_q]};
		qbit    = (trial >= divisor);
		if (qbit) begin
			rem_next = DIV_W'(trial - divisor);
		end else begin
			rem_next = DIV_W'(trial);
		end
	end

	assign mult_val  = {1'b0, mult_q} + (MULT_W+1)'(1);
	assign match     = ((prod_s1 >> shift_s1) == PROD_W'(target_q));
	assign last_cand = (shift_q == SHIFT_W'(MAX_OUT_SHIFT)) &&
		(mult_q == MULT_W'(MAX_MULT - 1)) && (div_q == DIV_W'(MAX_IN_DIV - 1));

	always_ff @(posedge clk) begin
		if (accept) begin
			src_q    <= in_beat.use_internal_rc ? RC_HZ : osc_q;
			target_q <= in_beat.target_hz;
			range_q  <= in_beat.use_internal_rc ? RANGE_W'(1) : osc_range;
			rem_q    <= '0;
			quot_q   <= '0;
		end else if (state_q == ST_DIVIDE) begin
			quot_q <= {quot_q[OSC_W-2:0], qbit};
			if (bit_q == '0) begin
				quot_mem_q[dsel_q] <= {quot_q[OSC_W-2:0], qbit};
				rem_q              <= '0;
			end else begin
				rem_q <= rem_next;
			end
		end
		prod_s1  <= PROD_W'(quot_mem_q[div_q]) * PROD_W'(mult_val);
		shift_s1 <= shift_q;
		mult_s1  <= mult_q;
		div_s1   <= div_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			osc_q       <= OSC_RESET_HZ;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			res_q       <= '0;
			dsel_q      <= '0;
			bit_q       <= '0;
			issue_q     <= 1'b0;
			shift_q     <= '0;
			mult_q      <= '0;
			div_q       <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				osc_q <= cfg_write_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			valid_s1 <= (state_q == ST_SEARCH) && issue_q && !(valid_s1 && match);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!in_beat.use_internal_rc && (osc_range == '0)) begin
							res_q   <= '{STATUS_TOO_FAST, '0, '0, '0, '0};
							state_q <= ST_FINISH;
						end else begin
							dsel_q  <= '0;
							bit_q   <= BIT_W'(OSC_W - 1);
							state_q <= ST_DIVIDE;
						end
					end
				end
				ST_DIVIDE: begin
					if (bit_q == '0) begin
						bit_q <= BIT_W'(OSC_W - 1);
						if (dsel_q == DIV_W'(MAX_IN_DIV - 1)) begin
							issue_q <= 1'b1;
							shift_q <= SHIFT_W'(1);
							mult_q  <= '0;
							div_q   <= '0;
							state_q <= ST_SEARCH;
						end else begin
							dsel_q <= dsel_q + DIV_W'(1);
						end
					end else begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				ST_SEARCH: begin
					if (valid_s1 && match) begin
						issue_q <= 1'b0;
						res_q   <= '{STATUS_FOUND, range_q, shift_s1, mult_s1, div_s1};
						state_q <= ST_FINISH;
					end else if (issue_q) begin
						if (last_cand) begin
							issue_q <= 1'b0;
						end else if (div_q == DIV_W'(MAX_IN_DIV - 1)) begin
							div_q <= '0;
							if (mult_q == MULT_W'(MAX_MULT - 1)) begin
								mult_q  <= '0;
								shift_q <= shift_q + SHIFT_W'(1);
							end else begin
								mult_q <= mult_q + MULT_W'(1);
							end
						end else begin
							div_q <= div_q + DIV_W'(1);
						end
					end else if (!valid_s1) begin
						res_q   <= '{STATUS_NO_SOLUTION, range_q, '0, '0, '0};
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/pds_checker.sv =====
// Port-level checker for the PLL divider search core, attached by the bind below.
// Depends on pds_pkg for the beat types and status codes.

module pds_checker
	import pds_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input out_beat_t        out_beat
);

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_beat))
		else $error("result beat changed while stalled");

	// The core is busy right after it takes a beat.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again without a search in between");

	// A found triple always carries a legal range and a nonzero output shift.
	a_found_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_beat.status == STATUS_FOUND) |->
		(out_beat.output_shift != '0) &&
		(out_beat.output_shift <= SHIFT_W'(MAX_OUT_SHIFT)) &&
		(out_beat.input_range_code != '0))
		else $error("found result with illegal shift or range");

	// An oscillator that is too fast reports nothing else.
	a_too_fast_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_beat.status == STATUS_TOO_FAST) |->
		(out_beat.input_range_code == '0) && (out_beat.output_shift == '0) &&
		(out_beat.mult_code == '0) && (out_beat.in_div_code == '0))
		else $error("too-fast result with nonzero fields");

	// A failed search keeps its range but reports no triple.
	a_no_solution_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_beat.status == STATUS_NO_SOLUTION) |->
		(out_beat.input_range_code != '0) && (out_beat.output_shift == '0) &&
		(out_beat.mult_code == '0) && (out_beat.in_div_code == '0))
		else $error("no-solution result with a triple or without a range");

endmodule

bind pll_divider_search_core pds_checker u_pds_checker (.*);

// ===== verif/pll_divider_checker.sv =====
`timescale 1ns / 1ps
// Checker for the PLL divider search core: it watches the register port and both channels,
// predicts every result beat by its own divider search and compares it field by field.
// Depends on pds_pkg for the beat types, widths and status codes.

module pll_divider_checker
	import pds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write_en,
	input  logic [OSC_W-1:0] cfg_write_data,
	input  logic             in_valid,
	input  logic             in_stall,
	input  in_beat_t         in_beat,
	input  logic             out_valid,
	input  logic             out_stall,
	input  out_beat_t        out_beat,
	output int               fail_count,
	output int               pending
);

	localparam logic [63:0] INTERNAL_RC_HZ = 64'd8000000;

	logic [OSC_W-1:0] osc_hz;
	out_beat_t planned_codes[$];
	int bad_beats = 0;

	function automatic logic [2:0] range_code(logic [63:0] hz);
		if (hz < 64'd10000000) return 3'd1;
		if (hz < 64'd16000000) return 3'd2;
		if (hz < 64'd26000000) return 3'd3;
		if (hz < 64'd42000000) return 3'd4;
		if (hz < 64'd64000000) return 3'd5;
		return 3'd0;
	endfunction

	function automatic out_beat_t search_dividers(in_beat_t b, logic [OSC_W-1:0] osc);
		out_beat_t r;
		logic [63:0] src;
		logic [63:0] f;
		r = '0;
		src = b.use_internal_rc ? INTERNAL_RC_HZ : 64'(osc);
		r.input_range_code = b.use_internal_rc ? 3'd1 : range_code(src);
		if (r.input_range_code == 3'd0) begin
			r.status = STATUS_TOO_FAST;
			return r;
		end
		for (int s = 1; s <= 5; s++)
			for (int m = 1; m <= 128; m++)
				for (int d = 1; d <= 8; d++) begin
					f = ((src / 64'(d)) * 64'(m)) >> s;
					if (f == 64'(b.target_hz)) begin
						r.status = STATUS_FOUND;
						r.output_shift = 3'(s);
						r.mult_code = 7'(m - 1);
						r.in_div_code = 3'(d - 1);
						return r;
					end
				end
		r.status = STATUS_NO_SOLUTION;
		return r;
	endfunction

	function automatic void note_bad(string what, out_beat_t want);
		bad_beats++;
		if (bad_beats <= 10)
			$display("%0t: %s: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
				$time, what, want.status, want.input_range_code, want.output_shift,
				want.mult_code, want.in_div_code, out_beat.status, out_beat.input_range_code,
				out_beat.output_shift, out_beat.mult_code, out_beat.in_div_code);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			osc_hz <= OSC_W'(8000000);
		end else if (cfg_write_en) begin
			osc_hz <= cfg_write_data;
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (planned_codes.size() == 0) begin
					note_bad("result beat with none pending", '0);
				end else begin
					want = planned_codes.pop_front();
					if (want.status !== out_beat.status
						|| want.input_range_code !== out_beat.input_range_code
						|| want.output_shift !== out_beat.output_shift
						|| want.mult_code !== out_beat.mult_code
						|| want.in_div_code !== out_beat.in_div_code)
						note_bad("result beat differs", want);
				end
			end
			if (in_valid && !in_stall)
				planned_codes.push_back(search_dividers(in_beat, osc_hz));
			pending <= planned_codes.size();
			fail_count <= bad_beats;
		end
	end

endmodule

// ===== verif/tb_pll_divider_search_core.sv =====
`timescale 1ns / 1ps
// Testbench top for the PLL divider search core: clock, reset, register writes and stimulus.
// Depends on pds_pkg, pll_divider_search_core and pll_divider_checker.

module tb_pll_divider_search_core;
	import pds_pkg::*;

	localparam int STUCK_LIMIT = 30000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write_en = 1'b0;
	logic [OSC_W-1:0] cfg_write_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_beat_t in_beat = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_beat_t out_beat;
	int fail_count;
	int pending;

	logic [OSC_W-1:0] osc_now = OSC_W'(8000000);
	logic quiet = 1'b0;
	bit idle_mode = 1'b1;
	bit stall_mode = 1'b1;
	int stall_left = 0;
	int stuck_cycles = 0;
	int random_sent = 0;
	int unsigned osc_edges[12] = '{67108863, 64000000, 63999999, 42000000, 41999999,
		26000000, 25999999, 16000000, 15999999, 10000000, 9999999, 0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pll_divider_search_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_beat        (in_beat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_beat       (out_beat)
	);

	pll_divider_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_beat        (in_beat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_beat       (out_beat),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) stall_mode = !stall_mode;
		if (quiet) begin
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stall_mode && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("pll_divider_search_core: mismatch");
				$finish;
			end
		end
	end

	function automatic logic [31:0] hit_target(logic [63:0] src);
		int s;
		int m;
		int d;
		s = $urandom_range(1, 5);
		m = $urandom_range(1, 128);
		d = $urandom_range(1, 8);
		return 32'(((src / 64'(d)) * 64'(m)) >> s);
	endfunction

	function automatic logic [OSC_W-1:0] choose_osc();
		case ($urandom_range(0, 4))
			0: return OSC_W'($urandom_range(0, 63999999));
			1: return OSC_W'($urandom);
			2: return OSC_W'(osc_edges[$urandom_range(0, 11)]);
			3: return OSC_W'($urandom_range(0, 2000));
			default: return OSC_W'($urandom_range(4000000, 41999999));
		endcase
	endfunction

	task automatic send(input logic [31:0] target, input logic rc);
		in_beat_t b;
		b.target_hz = target;
		b.use_internal_rc = rc;
		in_beat <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (!quiet && idle_mode && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic set_osc(input logic [OSC_W-1:0] hz);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_write_data <= hz;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		osc_now = hz;
	endtask

	task automatic random_item();
		logic rc;
		logic [31:0] target;
		int pick;
		rc = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 75) target = hit_target(rc ? 64'd8000000 : 64'(osc_now));
		else if (pick < 88) target = $urandom;
		else target = $urandom_range(0, 1000);
		random_sent++;
		if (random_sent >= 85) quiet <= 1'b1;
		send(target, rc);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		send(32'd0, 1'b0);
		send(32'hFFFFFFFF, 1'b1);
		send(32'd4000000, 1'b1);
		send(32'd512000000, 1'b1);
		send(32'd31250, 1'b0);
		foreach (osc_edges[i]) begin
			set_osc(OSC_W'(osc_edges[i]));
			send(hit_target(64'(osc_edges[i])), 1'b0);
			if (osc_edges[i] >= 64000000) send(32'd4000000, 1'b1);
		end
		send(32'd1, 1'b0);
		for (int p = 0; p < 5; p++) begin
			idle_mode = (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
			set_osc(choose_osc());
			repeat (20) random_item();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (6000) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("pll_divider_search_core: match");
		end else begin
			$display("pll_divider_search_core: mismatch");
		end
		$finish;
	end

endmodule
